FILE: rtl/hcx_pkg.sv
// shared types, constants and sha-256 helper functions for the keystream xor block
package hcx_pkg;

	// apb register map: four 64-bit key words at byte addresses 0, 8, 16, 24
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int KEY_WORDS = 4;

	typedef logic [KEY_WORDS-1:0][DATA_W-1:0] key_t;

	// top level sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_OUT
	} ctl_state_t;

	// compression unit sequencer
	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_FINAL
	} core_state_t;

	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [4:0] LAST_POS = 5'd31;

	// fixed message tail: 0x80 pad byte and a 288-bit length
	localparam logic [31:0] MSG_PAD_WORD = 32'h8000_0000;
	localparam logic [31:0] MSG_LEN_WORD = 32'h0000_0120;

	localparam logic [0:7][31:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] SHA_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

FILE: rtl/hcx_sha_core.sv
// sha-256 compression unit: one round per cycle over a 16-word message window
module hcx_sha_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  hcx_pkg::key_t key,
	input  logic [31:0]   counter,
	output logic          done,
	output logic [255:0]  digest
);
	import hcx_pkg::*;

	core_state_t state_q, state_nxt;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [15:0][31:0] w_q;
	logic [31:0] t1, t2, w_new;

	// round datapath
	always_comb begin
		t1 = h_q + big_sigma1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + SHA_K[rnd_q] + w_q[0];
		t2 = big_sigma0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
		w_new = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);
	end

	// feed-forward of the initial hash value
	assign digest = {SHA_IV[0] + a_q, SHA_IV[1] + b_q, SHA_IV[2] + c_q, SHA_IV[3] + d_q,
		SHA_IV[4] + e_q, SHA_IV[5] + f_q, SHA_IV[6] + g_q, SHA_IV[7] + h_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		done = 1'b0;
		case (state_q)
			CORE_IDLE: begin
				if (start) state_nxt = CORE_ROUND;
			end
			CORE_ROUND: begin
				if (rnd_q == LAST_ROUND) state_nxt = CORE_FINAL;
			end
			CORE_FINAL: begin
				done = 1'b1;
				state_nxt = CORE_IDLE;
			end
			default: state_nxt = CORE_IDLE;
		endcase
	end

	// working variables, round count and message window
	always_ff @(posedge clk) begin
		if (state_q == CORE_IDLE && start) begin
			{a_q, b_q, c_q, d_q} <= {SHA_IV[0], SHA_IV[1], SHA_IV[2], SHA_IV[3]};
			{e_q, f_q, g_q, h_q} <= {SHA_IV[4], SHA_IV[5], SHA_IV[6], SHA_IV[7]};
			rnd_q <= '0;
			for (int k = 0; k < KEY_WORDS; k++) begin
				w_q[2*k]   <= key[k][63:32];
				w_q[2*k+1] <= key[k][31:0];
			end
			// counter goes in little-endian byte order
			w_q[8]  <= {counter[7:0], counter[15:8], counter[23:16], counter[31:24]};
			w_q[9]  <= MSG_PAD_WORD;
			w_q[10] <= '0;
			w_q[11] <= '0;
			w_q[12] <= '0;
			w_q[13] <= '0;
			w_q[14] <= '0;
			w_q[15] <= MSG_LEN_WORD;
		end else if (state_q == CORE_ROUND) begin
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
			rnd_q <= rnd_q + 6'd1;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

endmodule

FILE: rtl/hash_counter_keystream_xor.sv
// byte-serial sha-256 counter-mode keystream xor with apb key registers
//
//  channel   signals                                   dir   width
//  input     in_valid, in_ready, data_byte, last_byte  in    8 + 1
//  output    out_valid, out_ready, out_byte            out   8
//  config    psel, penable, pwrite, paddr, pwdata,     in    5 addr, 64 data
//            prdata, pready
//
// an item at chunk position zero reaches the output register through the
// rounds of the shared sha-256 round unit, a feed-forward step and an xor
// step; any other item of a 32-byte chunk takes only the xor step. the block
// takes one item at a time and accepts the next while the previous result
// waits in the output register. an output stall holds the xor step. reset
// clears keys, position and counter.
module hash_counter_keystream_xor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hcx_pkg::ADDR_W-1:0] paddr,
	input  logic [hcx_pkg::DATA_W-1:0] pwdata,
	output logic [hcx_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import hcx_pkg::*;

	ctl_state_t  state_q, state_nxt;
	key_t        key_q;
	logic [4:0]  pos_q;
	logic [31:0] ctr_q;
	logic [255:0] ks_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        in_acc, core_start, core_done, out_load;
	logic [255:0] core_digest;

	assign in_acc = in_valid && in_ready;
	assign core_start = in_acc && (pos_q == '0);

	// apb key registers
	assign pready = 1'b1;
	assign prdata = key_q[paddr[4:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[paddr[4:3]] <= pwdata;
		end
	end

	hcx_sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (core_start),
		.key     (key_q),
		.counter (ctr_q),
		.done    (core_done),
		.digest  (core_digest)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and handshake
	always_comb begin
		state_nxt = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_nxt = (pos_q == '0) ? ST_HASH : ST_OUT;
			end
			ST_HASH: begin
				if (core_done) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// item capture and keystream block
	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= data_byte;
			last_q <= last_byte;
		end
		if (state_q == ST_HASH && core_done) ks_q <= core_digest;
		// byte p sits at bits 255-8p down
		if (out_load) out_byte_q <= data_q ^ ks_q[{~pos_q, 3'b000} +: 8];
	end

	// position, counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ctr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					pos_q <= '0;
					ctr_q <= '0;
				end else begin
					pos_q <= pos_q + 5'd1;
					if (pos_q == LAST_POS) ctr_q <= ctr_q + 32'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;

endmodule

FILE: rtl/hcx_checker.sv
// port-level checker for the keystream xor block and its bind
module hcx_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [7:0]                 out_byte,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [hcx_pkg::ADDR_W-1:0] paddr,
	input logic [hcx_pkg::DATA_W-1:0] pwdata,
	input logic [hcx_pkg::DATA_W-1:0] prdata
);
	import hcx_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("stalled output item changed");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// a new result appears only out of the busy phase
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output item without work");

	// a key write reads back
	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) ##1 $stable(paddr[4:3]) |-> prdata == $past(pwdata))
		else $error("key register readback mismatch");

endmodule

bind hash_counter_keystream_xor hcx_checker u_hcx_checker (.*);

FILE: test/tb_hash_counter_keystream_xor.sv
// self-checking testbench for the sha-256 counter-mode keystream xor block
module tb_hash_counter_keystream_xor;
	import hcx_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int REG_STRIDE = 8;
	localparam int IDLE_PCT = 35;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 106;
	localparam int STEADY_FROM = 320;
	localparam int STEADY_TO = 470;
	localparam int DRAIN_CYCLES = 80;
	localparam int TIMEOUT_CYCLES = 400000;

	// sha-256 round constants and initial hash value
	localparam logic [0:63][31:0] ROUND_CONST = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [0:7][31:0] HASH_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	// single-byte buffers, a two-byte buffer, walking ones and zeros; the final
	// buffer stays open so the next key load lands in the middle of a chunk
	localparam byte_item_t DIRECTED [20] = '{
		'{8'h00, 1'b1}, '{8'hff, 1'b1}, '{8'h00, 1'b0}, '{8'hff, 1'b1},
		'{8'h01, 1'b0}, '{8'h02, 1'b0}, '{8'h04, 1'b0}, '{8'h08, 1'b0},
		'{8'h10, 1'b0}, '{8'h20, 1'b0}, '{8'h40, 1'b0}, '{8'h80, 1'b0},
		'{8'hfe, 1'b0}, '{8'hfd, 1'b0}, '{8'hfb, 1'b0}, '{8'hf7, 1'b0},
		'{8'hef, 1'b0}, '{8'hdf, 1'b0}, '{8'hbf, 1'b0}, '{8'h7f, 1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        out_byte;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// predictor state
	key_t        key_copy = '0;
	logic [255:0] ks_block = '0;
	logic [4:0]  chunk_pos = '0;
	logic [31:0] block_idx = '0;
	logic [7:0]  expected_bytes [$];

	logic steady = 1'b0;
	int   buf_left = 0;
	int   errors = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   n_buffers = 0;
	int   n_blocks = 0;
	int   n_key_loads = 0;

	hash_counter_keystream_xor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// sha-256 over key bytes 0..31 followed by the little-endian block counter
	function automatic logic [255:0] block_digest(input key_t key, input logic [31:0] ctr);
		logic [511:0] msg;
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		msg = {key[0], key[1], key[2], key[3], ctr[7:0], ctr[15:8], ctr[23:16], ctr[31:24],
			8'h80, 152'd0, 64'd288};
		for (int j = 0; j < 16; j++)
			w[j] = msg[511 - 32 * j -: 32];
		for (int j = 16; j < 64; j++)
			w[j] = w[j - 16] + w[j - 7]
				+ (rotr(w[j - 15], 7) ^ rotr(w[j - 15], 18) ^ (w[j - 15] >> 3))
				+ (rotr(w[j - 2], 17) ^ rotr(w[j - 2], 19) ^ (w[j - 2] >> 10));
		{a, b, c, d, e, f, g, h} = HASH_INIT;
		for (int j = 0; j < 64; j++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_CONST[j] + w[j];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		return {HASH_INIT[0] + a, HASH_INIT[1] + b, HASH_INIT[2] + c, HASH_INIT[3] + d,
			HASH_INIT[4] + e, HASH_INIT[5] + f, HASH_INIT[6] + g, HASH_INIT[7] + h};
	endfunction

	// xor one byte with the keystream and advance position and counter
	task automatic xor_next_byte(input logic [7:0] d, input logic l, output logic [7:0] o);
		if (chunk_pos == 5'd0) begin
			ks_block = block_digest(key_copy, block_idx);
			n_blocks++;
		end
		o = d ^ ks_block[255 - 8 * int'(chunk_pos) -: 8];
		if (l) begin
			chunk_pos = 5'd0;
			block_idx = 32'd0;
			n_buffers++;
		end else begin
			chunk_pos = chunk_pos + 5'd1;
			if (chunk_pos == 5'd0)
				block_idx = block_idx + 32'd1;
		end
	endtask

	// predict on each accepted item, compare each accepted result
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				xor_next_byte(data_byte, last_byte, want);
				expected_bytes.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected out_byte, expected none, actual %h", $time, out_byte);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					n_checked++;
					if (out_byte !== want) begin
						$display("%0t: out_byte mismatch, expected %h, actual %h",
							$time, want, out_byte);
						errors++;
					end
				end
			end
		end
	end

	// receiver stalls at random outside the steady stretch
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	// offer one item, idling first at random
	task automatic send_byte(input logic [7:0] d, input logic l);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	task automatic wait_all_results;
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
	endtask

	// write the selected key words over the apb port
	task automatic load_keys(input key_t k, input logic [KEY_WORDS-1:0] mask);
		for (int i = 0; i < KEY_WORDS; i++) begin
			if (mask[i]) begin
				psel <= 1'b1;
				penable <= 1'b0;
				pwrite <= 1'b1;
				paddr <= ADDR_W'(i * REG_STRIDE);
				pwdata <= k[i];
				@(posedge clk);
				penable <= 1'b1;
				do @(posedge clk); while (!pready);
				key_copy[i] = k[i];
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
		n_key_loads++;
	endtask

	// stimulus
	initial begin
		key_t k;
		logic [KEY_WORDS-1:0] mask;
		int sel;
		int rnd_idx;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		last_byte <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		rnd_idx = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items under the reset key
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].data, DIRECTED[i].last);
		wait_all_results();

		// random phases, each under a new key setting
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			for (int i = 0; i < KEY_WORDS; i++)
				k[i] = {$urandom, $urandom};
			mask = {KEY_WORDS{1'b1}};
			case (phase)
				0: k = '1;
				1: k = '0;
				2: k = {64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
					64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff};
				default: mask = KEY_WORDS'($urandom_range(1, (1 << KEY_WORDS) - 1));
			endcase
			load_keys(k, mask);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				steady <= (rnd_idx >= STEADY_FROM) && (rnd_idx < STEADY_TO);
				// buffers of mixed length, some cut across a key load
				if (buf_left == 0) begin
					sel = $urandom_range(0, 99);
					buf_left = (sel < 25) ? $urandom_range(1, 4)
						: (sel < 60) ? $urandom_range(5, 40) : $urandom_range(41, 100);
				end
				send_byte(8'($urandom_range(0, 255)), buf_left == 1);
				buf_left--;
				rnd_idx++;
			end
			wait_all_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d items in %0d closed buffers under %0d key loads",
			n_sent, n_buffers, n_key_loads);
		$display("%0d keystream blocks predicted, %0d results checked, %0d mismatches",
			n_blocks, n_checked, errors);
		if (errors == 0 && expected_bytes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("TEST FAILED");
		$finish;
	end

endmodule
